FILE: rtl/core/lpfc_pkg.sv
`default_nettype none
package lpfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Shortest well-formed frame: length, address, answer/check.
  localparam logic [7:0] MIN_FRAME_LEN = 8'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CHECK_ERR = 2'd1,
    STATUS_ADDR_ERR  = 2'd2,
    STATUS_MALFORMED = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_START = 1'b1
  } kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic [7:0] expected_address;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] responder_address;
    logic [7:0] answer_code;
    logic [7:0] frame_length;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] expected_address;
  } cmd_t;

  // CRC-16 CCITT, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lpfc_front.sv
`default_nettype none
module lpfc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lpfc_pkg::in_item_t in_item,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output lpfc_pkg::cmd_t         cmd
);

  logic           valid_r;
  logic           valid_nxt;
  lpfc_pkg::cmd_t cmd_r;
  lpfc_pkg::cmd_t cmd_nxt;

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt             = 1'b1;
      // classify: start action or received byte
      cmd_nxt.kind             = in_item.action ? lpfc_pkg::KIND_START : lpfc_pkg::KIND_BYTE;
      cmd_nxt.data_byte        = in_item.data_byte;
      cmd_nxt.expected_address = in_item.expected_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/lpfc_queue.sv
`default_nettype none
module lpfc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire lpfc_pkg::cmd_t wr_cmd,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output lpfc_pkg::cmd_t      rd_cmd
);

  localparam int unsigned CNT_W = $clog2(lpfc_pkg::QUEUE_DEPTH + 1);

  lpfc_pkg::cmd_t                     mem_r [lpfc_pkg::QUEUE_DEPTH];
  logic [lpfc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [lpfc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]                   count_r;
  logic                               push;
  logic                               pop;

  assign wr_ready = (count_r != CNT_W'(lpfc_pkg::QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == lpfc_pkg::QUEUE_PTR_W'(lpfc_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == lpfc_pkg::QUEUE_PTR_W'(lpfc_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lpfc_back.sv
`default_nettype none
module lpfc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire lpfc_pkg::cmd_t cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lpfc_pkg::out_item_t out_item
);

  logic [7:0]  byte_count_r,   byte_count_nxt;
  logic [15:0] crc_r,          crc_nxt;
  logic [7:0]  length_r,       length_nxt;
  logic [7:0]  address_r,      address_nxt;
  logic [7:0]  answer_r,       answer_nxt;
  logic [7:0]  wanted_r,       wanted_nxt;
  logic        done_r,         done_nxt;
  logic        out_valid_r,    out_valid_nxt;
  lpfc_pkg::out_item_t out_item_r, out_item_nxt;

  logic        take;
  logic [7:0]  b;
  logic [7:0]  len_eff;
  logic [7:0]  addr_eff;
  logic [7:0]  ans_eff;
  logic [8:0]  next_count;

  assign cmd_ready = !out_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign b          = cmd.data_byte;
  assign next_count = {1'b0, byte_count_r} + 9'd1;
  assign len_eff    = (byte_count_r == 8'd0) ? b : length_r;
  assign addr_eff   = (byte_count_r == 8'd1) ? b : address_r;
  assign ans_eff    = (byte_count_r == 8'd2) ? b : answer_r;

  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    length_nxt     = length_r;
    address_nxt    = address_r;
    answer_nxt     = answer_r;
    wanted_nxt     = wanted_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;

    if (take) begin
      case (cmd.kind)
        lpfc_pkg::KIND_START: begin
          byte_count_nxt = '0;
          crc_nxt        = lpfc_pkg::CRC_INIT;
          length_nxt     = '0;
          address_nxt    = '0;
          answer_nxt     = '0;
          done_nxt       = 1'b0;
          wanted_nxt     = cmd.expected_address;
        end
        lpfc_pkg::KIND_BYTE: begin
          if (!done_r) begin
            length_nxt  = len_eff;
            address_nxt = addr_eff;
            answer_nxt  = ans_eff;
            if (byte_count_r == 8'd0 && b < lpfc_pkg::MIN_FRAME_LEN) begin
              // malformed length: report at once, close frame
              done_nxt                       = 1'b1;
              byte_count_nxt                 = 8'd1;
              out_valid_nxt                  = 1'b1;
              out_item_nxt.status            = lpfc_pkg::STATUS_MALFORMED;
              out_item_nxt.responder_address = '0;
              out_item_nxt.answer_code       = '0;
              out_item_nxt.frame_length      = b;
            end else if (next_count == {1'b0, len_eff}) begin
              done_nxt                       = 1'b1;
              byte_count_nxt                 = next_count[7:0];
              out_valid_nxt                  = 1'b1;
              if (crc_r[7:0] != b) begin
                out_item_nxt.status = lpfc_pkg::STATUS_CHECK_ERR;
              end else if (addr_eff != wanted_r) begin
                out_item_nxt.status = lpfc_pkg::STATUS_ADDR_ERR;
              end else begin
                out_item_nxt.status = lpfc_pkg::STATUS_OK;
              end
              out_item_nxt.responder_address = addr_eff;
              out_item_nxt.answer_code       = ans_eff;
              out_item_nxt.frame_length      = len_eff;
            end else begin
              crc_nxt        = lpfc_pkg::crc16_byte(crc_r, b);
              byte_count_nxt = next_count[7:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= lpfc_pkg::CRC_INIT;
      length_r     <= '0;
      address_r    <= '0;
      answer_r     <= '0;
      wanted_r     <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      length_r     <= length_nxt;
      address_r    <= address_nxt;
      answer_r     <= answer_nxt;
      wanted_r     <= wanted_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/length_prefixed_frame_checker.sv
// Length-prefixed reply frame checker with CRC-16 CCITT.
// Input channel (in_valid/in_ready/in_item): one item per received byte
// (action 0, data_byte used) or a start request (action 1, loads the
// expected address and clears the receiver).
// Result channel (out_valid/out_ready/out_item): one result per frame with
// status, responder address, answer code and frame length; a length byte
// below three gives a malformed result at once.
// Path: the closing byte passes the front register, then the queue, then the
// result register of the frame engine, from which out_valid is driven.
// Throughput: one item per cycle, set by the combinational byte CRC update in
// the frame engine; in_ready stays high while results are taken.
// Reset (rst_n low, synchronous): queue empty, result slot empty, CRC at
// 0xFFFF, expected address 0, receiver cleared.
// Receiver stall: the result register holds; the engine stops and the
// two-entry queue plus the front register absorb items, then in_ready drops.
`default_nettype none
module length_prefixed_frame_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lpfc_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lpfc_pkg::out_item_t     out_item
);

  // front register -> queue
  logic           f_valid;
  logic           f_ready;
  lpfc_pkg::cmd_t f_cmd;

  // queue -> frame engine
  logic           q_valid;
  logic           q_ready;
  lpfc_pkg::cmd_t q_cmd;

  // Accept and classify each item.
  lpfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Decouple front from engine so each can stall alone.
  lpfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // Track frame state, run CRC, hold results.
  lpfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
